>>> hw/rtl/sbvd_pkg.sv
// Shared types, constants and helper functions for the spectral band voice detector.
package sbvd_pkg;

   // Frame geometry
   localparam int BINS_PER_FRAME_DEF = 64;
   localparam int BIN_W              = 6;

   // Payload widths
   localparam int BIN_VALUE_W = 24;
   localparam int SCORE_W     = 32;
   localparam int THRESH_W    = 14;
   localparam int LIMIT_W     = 20;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 1;
   localparam int RUN_W       = 16;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_THRESHOLD   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCORE_UPPER_LIMIT = 1'd1;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 14'd1000;
   localparam logic [LIMIT_W-1:0]  UPPER_LIMIT_RESET = 20'd10000;

   // Voice band store: bins 10..20
   localparam int BAND_LO     = 10;
   localparam int BAND_HI     = 20;
   localparam int BAND_LEN    = BAND_HI - BAND_LO + 1;
   localparam int BAND_ADDR_W = $clog2(BAND_LEN);
   localparam int PEAK_W      = 5;

   localparam logic [PEAK_W-1:0] FIRST_PEAK_RESET  = 5'd11;
   localparam logic [PEAK_W-1:0] SECOND_PEAK_RESET = 5'd12;

   // floor(6x/5) by reciprocal: 6x < 2^27, M = ceil(2^29/5), error 3 * 2^27 < 2^29
   localparam int                    SCALE_IN_W   = BIN_VALUE_W + 3;
   localparam int                    SCALE_OUT_W  = BIN_VALUE_W + 1;
   localparam int                    RECIP_SHIFT  = 29;
   localparam logic [SCALE_IN_W-1:0] RECIP_MULT   = 27'd107374183;

   // Weighting codes for a bin
   localparam logic [1:0] WEIGHT_NONE  = 2'd0;
   localparam logic [1:0] WEIGHT_SUB12 = 2'd1;
   localparam logic [1:0] WEIGHT_ADD   = 2'd2;
   localparam logic [1:0] WEIGHT_SUB   = 2'd3;

   typedef struct packed {
      logic                   wr_en;
      logic [BAND_ADDR_W-1:0] wr_addr;
      logic [BIN_VALUE_W-1:0] wr_data;
      logic [BAND_ADDR_W-1:0] rd_addr;
   } sbvd_store_req_type;

   function automatic logic [1:0] bin_weight(input logic [BIN_W-1:0] bin);
      logic [1:0] code;
      if (bin inside {[1:5]}) begin
         code = WEIGHT_SUB12;
      end else if (bin inside {[6:30]}) begin
         code = WEIGHT_ADD;
      end else if (bin inside {[40:60]}) begin
         code = WEIGHT_SUB;
      end else begin
         code = WEIGHT_NONE;
      end
      return code;
   endfunction

   function automatic logic in_voice_band(input logic [BIN_W-1:0] bin);
      return (bin inside {[BAND_LO:BAND_HI]});
   endfunction

endpackage

>>> hw/rtl/sbvd_scale.sv
// Reciprocal multiply unit: registered floor(12x/10) of one bin magnitude.
module sbvd_scale (
   input  logic                                 clock,
   input  logic [sbvd_pkg::BIN_VALUE_W-1:0]     value,
   output logic [sbvd_pkg::SCALE_OUT_W-1:0]     scaled_ff
);

   localparam int IN_W  = sbvd_pkg::SCALE_IN_W;
   localparam int PROD_W = 2 * IN_W;

   logic [IN_W-1:0]                   times6;
   logic [PROD_W-1:0]                 product;
   logic [sbvd_pkg::SCALE_OUT_W-1:0]  scaled_in;

   // 6x = 4x + 2x, then divide by 5 through the reciprocal
   assign times6    = {1'b0, value, 2'b00} + {2'b00, value, 1'b0};
   assign product   = {{IN_W{1'b0}}, times6} * {{IN_W{1'b0}}, sbvd_pkg::RECIP_MULT};
   assign scaled_in = product[sbvd_pkg::RECIP_SHIFT +: sbvd_pkg::SCALE_OUT_W];

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
   end

endmodule

>>> hw/rtl/sbvd_band_store.sv
// Voice band store: eleven bin magnitudes, one write and one registered read port.
module sbvd_band_store (
   input  logic                              clock,
   input  sbvd_pkg::sbvd_store_req_type      store_req,
   output logic [sbvd_pkg::BIN_VALUE_W-1:0]  rd_data_ff
);

   logic [sbvd_pkg::BIN_VALUE_W-1:0] mem [0:sbvd_pkg::BAND_LEN-1];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[store_req.rd_addr];
   end

endmodule

>>> hw/rtl/spectral_band_voice_detector_core.sv
// Spectral band voice detector top level: sequencer, shared adder and result register.
// A plain bin goes through accept, scale multiply and accumulate; req_stall is high after
//   each accepted request until its accumulate is done. A last bin reaches rsp_valid after
//   accept, multiply, accumulate, 3 fetch, 11-step peak scan (one store read a cycle),
//   2 peak adds, decide. One bin at a time; decide holds while an earlier result is stalled.
// Reset (synchronous): state to idle, threshold and limit to defaults; clears bin count,
//   score, run counter, result valid; peaks to 11/12.
module spectral_band_voice_detector_core #(
   parameter int BINS_PER_FRAME = sbvd_pkg::BINS_PER_FRAME_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sbvd_pkg::BIN_VALUE_W-1:0]      req_bin_value,
   input  logic                                  req_last_bin,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_voice_active,
   output logic signed [sbvd_pkg::SCORE_W-1:0]   rsp_frame_score,
   // configuration port
   input  logic                                  csr_wr_en,
   input  logic [sbvd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [sbvd_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int CNT_W   = $clog2(BINS_PER_FRAME);
   localparam int SCORE_W = sbvd_pkg::SCORE_W;
   localparam int VAL_W   = sbvd_pkg::BIN_VALUE_W;
   localparam int ADDR_W  = sbvd_pkg::BAND_ADDR_W;
   localparam int PEAK_W  = sbvd_pkg::PEAK_W;
   localparam int RUN_W   = sbvd_pkg::RUN_W;

   localparam logic [CNT_W-1:0]  LAST_BIN_IDX = CNT_W'(BINS_PER_FRAME - 1);
   localparam logic [ADDR_W-1:0] SCAN_LAST    = ADDR_W'(sbvd_pkg::BAND_LEN - 1);
   localparam logic [PEAK_W-1:0] BAND_LO_P    = PEAK_W'(sbvd_pkg::BAND_LO);
   localparam logic [RUN_W-1:0]  RUN_MAX      = {RUN_W{1'b1}};

   // Sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MULT    = 4'd1;
   localparam logic [3:0] ST_ACCUM   = 4'd2;
   localparam logic [3:0] ST_FETCH1  = 4'd3;
   localparam logic [3:0] ST_FETCH2  = 4'd4;
   localparam logic [3:0] ST_FETCH3  = 4'd5;
   localparam logic [3:0] ST_SCAN    = 4'd6;
   localparam logic [3:0] ST_ADD1    = 4'd7;
   localparam logic [3:0] ST_ADD2    = 4'd8;
   localparam logic [3:0] ST_DECIDE  = 4'd9;

   logic [3:0]                   state_ff, state_in;

   // Configuration registers
   logic [sbvd_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic [sbvd_pkg::LIMIT_W-1:0]  limit_ff, limit_in;

   // Frame state
   logic [CNT_W-1:0]             bin_cnt_ff, bin_cnt_in;
   logic signed [SCORE_W-1:0]    acc_ff, acc_in;
   logic [PEAK_W-1:0]            first_ff, first_in;
   logic [PEAK_W-1:0]            second_ff, second_in;
   logic [RUN_W-1:0]             run_ff, run_in;

   // Latched request (payload, no reset)
   logic [VAL_W-1:0]             value_ff, value_in;
   logic [1:0]                   weight_ff, weight_in;
   logic                         last_ff, last_in;

   // Peak scan payload
   logic [VAL_W-1:0]             p1val_ff, p1val_in;
   logic [VAL_W-1:0]             p2val_ff, p2val_in;
   logic [ADDR_W-1:0]            scan_ff, scan_in;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_active_ff, rsp_active_in;
   logic signed [SCORE_W-1:0]    rsp_score_ff, rsp_score_in;

   // Shared units
   logic [sbvd_pkg::SCALE_OUT_W-1:0] scaled_ff;
   logic [VAL_W-1:0]                 rd_data_ff;
   sbvd_pkg::sbvd_store_req_type     store_req;

   logic                         accept;
   logic                         rsp_free;
   logic [SCORE_W-1:0]           operand;
   logic                         subtract;
   logic [SCORE_W-1:0]           sum;
   logic [PEAK_W-1:0]            scan_bin;
   logic                         in_range;
   logic [RUN_W-1:0]             run_next;
   logic signed [SCORE_W-1:0]    thresh_s;
   logic signed [SCORE_W-1:0]    limit_s;

   sbvd_scale u_scale (
      .clock     (clock),
      .value     (value_ff),
      .scaled_ff (scaled_ff)
   );

   sbvd_band_store u_store (
      .clock      (clock),
      .store_req  (store_req),
      .rd_data_ff (rd_data_ff)
   );

   assign accept   = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign scan_bin = PEAK_W'(scan_ff) + BAND_LO_P;

   // Store the voice band bins as they arrive; walk the store during fetch and scan
   always_comb begin
      store_req.wr_en   = accept && sbvd_pkg::in_voice_band(bin_cnt_ff);
      store_req.wr_addr = ADDR_W'(bin_cnt_ff - CNT_W'(sbvd_pkg::BAND_LO));
      store_req.wr_data = req_bin_value;
      case (state_ff)
         ST_FETCH1: store_req.rd_addr = ADDR_W'(first_ff - BAND_LO_P);
         ST_FETCH2: store_req.rd_addr = ADDR_W'(second_ff - BAND_LO_P);
         ST_SCAN:   store_req.rd_addr = scan_ff + ADDR_W'(1);
         default:   store_req.rd_addr = '0;
      endcase
   end

   // Shared adder: the bin weighting and both peak additions go through it
   always_comb begin
      operand  = '0;
      subtract = 1'b0;
      case (state_ff)
         ST_ACCUM: begin
            case (weight_ff)
               sbvd_pkg::WEIGHT_SUB12: begin
                  operand  = SCORE_W'(scaled_ff);
                  subtract = 1'b1;
               end
               sbvd_pkg::WEIGHT_ADD: begin
                  operand  = SCORE_W'(value_ff);
               end
               sbvd_pkg::WEIGHT_SUB: begin
                  operand  = SCORE_W'(value_ff);
                  subtract = 1'b1;
               end
               default: begin
                  operand  = '0;
               end
            endcase
         end
         ST_ADD1: operand = SCORE_W'(p1val_ff);
         ST_ADD2: operand = SCORE_W'(p2val_ff);
         default: operand = '0;
      endcase
      sum = acc_ff + (subtract ? ~operand : operand) + SCORE_W'(subtract);
   end

   // Frame decision: threshold < score <= upper limit, both compared signed
   always_comb begin
      thresh_s = $signed(SCORE_W'(thresh_ff));
      limit_s  = $signed(SCORE_W'(limit_ff));
      in_range = (acc_ff > thresh_s) && (acc_ff <= limit_s);
      if (!in_range) begin
         run_next = '0;
      end else if (run_ff != RUN_MAX) begin
         run_next = run_ff + RUN_W'(1);
      end else begin
         run_next = run_ff;
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      thresh_in     = thresh_ff;
      limit_in      = limit_ff;
      bin_cnt_in    = bin_cnt_ff;
      acc_in        = acc_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      run_in        = run_ff;
      value_in      = value_ff;
      weight_in     = weight_ff;
      last_in       = last_ff;
      p1val_in      = p1val_ff;
      p2val_in      = p2val_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_active_in = rsp_active_ff;
      rsp_score_in  = rsp_score_ff;

      if (csr_wr_en) begin
         case (csr_index)
            sbvd_pkg::CSR_SCORE_THRESHOLD:
               thresh_in = csr_wdata[sbvd_pkg::THRESH_W-1:0];
            sbvd_pkg::CSR_SCORE_UPPER_LIMIT:
               limit_in  = csr_wdata[sbvd_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // latch the request and its weighting
            if (accept) begin
               value_in  = req_bin_value;
               last_in   = req_last_bin;
               weight_in = sbvd_pkg::bin_weight(bin_cnt_ff);
               state_in  = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc_in = sum;
            if (last_ff) begin
               bin_cnt_in = '0;
               state_in   = ST_FETCH1;
            end else begin
               bin_cnt_in = (bin_cnt_ff == LAST_BIN_IDX) ? '0 : bin_cnt_ff + CNT_W'(1);
               state_in   = ST_IDLE;
            end
         end
         ST_FETCH1: begin
            state_in = ST_FETCH2;
         end
         ST_FETCH2: begin
            p1val_in = rd_data_ff;
            state_in = ST_FETCH3;
         end
         ST_FETCH3: begin
            p2val_in = rd_data_ff;
            scan_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // one stored bin per cycle against the current two peaks
            if (rd_data_ff > p1val_ff) begin
               second_in = first_ff;
               p2val_in  = p1val_ff;
               first_in  = scan_bin;
               p1val_in  = rd_data_ff;
            end else if ((scan_bin != first_ff) && (rd_data_ff > p2val_ff)) begin
               second_in = scan_bin;
               p2val_in  = rd_data_ff;
            end
            if (scan_ff == SCAN_LAST) begin
               state_in = ST_ADD1;
            end else begin
               scan_in = scan_ff + ADDR_W'(1);
            end
         end
         ST_ADD1: begin
            acc_in   = sum;
            state_in = ST_ADD2;
         end
         ST_ADD2: begin
            acc_in   = sum;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // hold until the result register is free
            if (rsp_free) begin
               run_in        = run_next;
               rsp_valid_in  = 1'b1;
               rsp_active_in = (run_next > RUN_W'(1));
               rsp_score_in  = acc_ff;
               acc_in        = '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thresh_ff    <= sbvd_pkg::THRESHOLD_RESET;
         limit_ff     <= sbvd_pkg::UPPER_LIMIT_RESET;
         bin_cnt_ff   <= '0;
         acc_ff       <= '0;
         first_ff     <= sbvd_pkg::FIRST_PEAK_RESET;
         second_ff    <= sbvd_pkg::SECOND_PEAK_RESET;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         limit_ff     <= limit_in;
         bin_cnt_ff   <= bin_cnt_in;
         acc_ff       <= acc_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      weight_ff     <= weight_in;
      last_ff       <= last_in;
      p1val_ff      <= p1val_in;
      p2val_ff      <= p2val_in;
      scan_ff       <= scan_in;
      rsp_active_ff <= rsp_active_in;
      rsp_score_ff  <= rsp_score_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_voice_active = rsp_active_ff;
   assign rsp_frame_score  = rsp_score_ff;

endmodule
